@@ sv/dbcw_pkg.sv @@
package dbcw_pkg;

  localparam int HistDepth = 4;
  localparam int PtrW = $clog2(HistDepth);
  localparam int PredShift = PtrW + 16;
  localparam logic [15:0] MaxWindow = 16'hFFFF;
  localparam logic [15:0] ResetThreshold = 16'd80;
  localparam logic [15:0] ResetWindow = 16'd32;
  localparam logic [16:0] GrowNum = 17'd98304;

  localparam int DivW = 128;

  localparam logic [0:0] RegThreshold = 1'b0;
  localparam logic [0:0] RegInitWindow = 1'b1;

  localparam logic OpSent = 1'b0;
  localparam logic OpAck = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] seq_number;
    logic [31:0] sent_time;
    logic [31:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cwnd;
    logic [15:0] timeout_value;
    logic [31:0] rtt_used;
    logic [31:0] min_rtt;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/dbcw_div.sv @@
module dbcw_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dbcw_pkg::div_req_t req,
  output dbcw_pkg::div_rsp_t rsp
);
  import dbcw_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DivW-1:0] num_r, num_nxt;
  logic [DivW-1:0] den_r, den_nxt;
  logic [DivW-1:0] rem_r, rem_nxt;
  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, num_r[DivW-1]};
    diff     = shifted - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(DivW);
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[DivW]) begin
        rem_nxt = diff[DivW-1:0];
        num_nxt = {num_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DivW-1:0];
        num_nxt = {num_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = num_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("quotient done without a run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider still busy at done");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !$past(req.start) |-> cnt_r == '0 || done_r || !$past(busy_r))
    else $error("counter left running");

endmodule

@@ sv/delay_based_congestion_window_top.sv @@
// Channel     | Direction | Handshake             | Payload
// in_         | input     | in_valid / in_ready   | in_item   (dbcw_pkg::in_item_t)
// out_        | output    | out_valid / out_ready | out_item  (dbcw_pkg::out_item_t)
// cfg_        | input     | APB psel/penable      | 32-bit registers at 0x0 and 0x4
//
// A sent transaction passes from acceptance through S_OUT into the output register. An
// ack that needs no prediction spends most of its time in runs of the shared 128-bit
// restoring divider (one bit per cycle). A full-ring ack that decreases the window
// takes the longest path: sums over the ring, the S_PAIR, S_PAIRMUL and S_PAIRACC
// steps per pair on a single multiplier, then divider runs for the slope, the decrease
// factor and the window; the prediction is rounded with a shift.
// Reset (rst_n low, synchronous) loads the register defaults and clears the ring.
// in_ready is low while a transaction is in work or its result waits; a stalled
// result simply holds in the output register and blocks the next acceptance.
module delay_based_congestion_window_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dbcw_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dbcw_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import dbcw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ACK, S_SUMS, S_PAIR, S_PAIRMUL, S_PAIRACC, S_SLOPE, S_SLOPEW,
    S_LEVER, S_PMUL0, S_PMUL1, S_PMUL2, S_PMUL3, S_PSUM, S_PCLAMP,
    S_DECIDE, S_FACT, S_FACTW, S_WDIV, S_WDIVW, S_GROW, S_GROWW, S_OUT
  } state_t;

  state_t          state_r;
  logic [15:0]     thresh_r, initw_r;
  logic [15:0]     win_r;
  logic [31:0]     acc_r;
  logic [31:0]     floor_r;
  logic [31:0]     last_seq_r, holdoff_r, prev_arr_r;
  logic [31:0]     time_ring_r [HistDepth];
  logic [31:0]     rtt_ring_r [HistDepth];
  logic [PtrW-1:0] ptr_r;
  logic            full_r;
  in_item_t        item_r;
  logic [31:0]     rtt_r;
  // Fit working registers.
  logic [PtrW-1:0] pi_r, pj_r;
  logic signed [33:0] sx_r;
  logic [33:0]     sy_r;
  logic [32:0]     mdx_r, mdy_r;
  logic            crneg_r;
  logic [65:0]     sq_r;
  logic [DivW-1:0] den_r, num_r;
  logic            sneg_r;
  logic [63:0]     slope_r;
  logic [35:0]     lever_r;
  logic            lneg_r;
  logic [DivW-1:0] pacc_r;
  logic [31:0]     half_r;
  out_item_t       out_r;
  logic            out_valid_r;

  div_req_t        dreq;
  div_rsp_t        drsp;

  dbcw_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Timeout from the current floor and threshold.
  logic [32:0] t2;
  logic [15:0] tmo;
  assign t2  = {floor_r, 1'b0};
  assign tmo = (t2 < {17'd0, thresh_r}) ? t2[15:0] : thresh_r;

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr)
      3'd0:    cfg_prdata = {16'd0, thresh_r};
      3'd4:    cfg_prdata = {16'd0, initw_r};
      default: cfg_prdata = '0;
    endcase
  end

  // The single 33x33 multiplier, operands picked by state.
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  always_comb begin
    mul_a = mdx_r;
    mul_b = mdy_r;
    unique case (state_r)
      S_PAIRMUL: begin mul_a = mdx_r; mul_b = mdx_r; end
      S_PMUL0: begin mul_a = {1'b0, slope_r[31:0]};  mul_b = {15'd0, lever_r[17:0]}; end
      S_PMUL1: begin mul_a = {1'b0, slope_r[31:0]};  mul_b = {15'd0, lever_r[35:18]}; end
      S_PMUL2: begin mul_a = {1'b0, slope_r[63:32]}; mul_b = {15'd0, lever_r[17:0]}; end
      S_PMUL3: begin mul_a = {1'b0, slope_r[63:32]}; mul_b = {15'd0, lever_r[35:18]}; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic signed [32:0] xi, xj;
  logic signed [33:0] dx;
  logic signed [32:0] dy;
  assign xi = 33'(signed'(time_ring_r[pi_r] - item_r.arrival_time));
  assign xj = 33'(signed'(time_ring_r[pj_r] - item_r.arrival_time));
  assign dx = 34'(xi) - 34'(xj);
  assign dy = $signed({1'b0, rtt_ring_r[pi_r]}) - $signed({1'b0, rtt_ring_r[pj_r]});

  logic [31:0] arr, meas;
  assign arr  = item_r.arrival_time;
  assign meas = arr - item_r.sent_time;

  // The lever uses the previous ack's arrival time, so on the fit path prev_arr_r is
  // only refreshed in the slope step, where the lever is captured.
  logic signed [35:0] lever_s;
  assign lever_s = 36'(signed'(arr - prev_arr_r)) * 36'(HistDepth) - 36'(sx_r);

  logic [DivW-1:0] ptot;
  assign ptot = pacc_r;

  // The prediction divides by a power of two: round up, then shift.
  logic [DivW-1:0] pround, pq;
  assign pround = pacc_r + DivW'((1 << PredShift) - 1);
  assign pq     = pround >> PredShift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thresh_r    <= ResetThreshold;
      initw_r     <= ResetWindow;
      win_r       <= ResetWindow;
      acc_r       <= {ResetWindow, 16'd0};
      floor_r     <= {16'd0, ResetThreshold};
      last_seq_r  <= '0;
      holdoff_r   <= '0;
      prev_arr_r  <= '0;
      ptr_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dreq.start  <= 1'b0;
      for (int k = 0; k < HistDepth; k++) begin
        time_ring_r[k] <= '0;
        rtt_ring_r[k]  <= '0;
      end
    end else begin
      if (cfg_wr && cfg_paddr == 3'd0) begin
        thresh_r <= cfg_pwdata[15:0];
        floor_r  <= {16'd0, cfg_pwdata[15:0]};
      end else if (cfg_wr && cfg_paddr == 3'd4) begin
        initw_r <= cfg_pwdata[15:0];
        win_r   <= (cfg_pwdata[15:0] == 16'd0) ? 16'd1 : cfg_pwdata[15:0];
        acc_r   <= {((cfg_pwdata[15:0] == 16'd0) ? 16'd1 : cfg_pwdata[15:0]), 16'd0};
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          item_r <= in_item;
          if (in_item.opcode == OpSent) begin
            last_seq_r <= in_item.seq_number;
            rtt_r      <= '0;
            state_r    <= S_OUT;
          end else begin
            state_r <= S_ACK;
          end
        end
        S_ACK: begin
          rtt_r <= meas;
          if (meas < floor_r) floor_r <= meas;
          time_ring_r[ptr_r] <= arr;
          rtt_ring_r[ptr_r]  <= meas;
          if (full_r || ptr_r == PtrW'(HistDepth - 1)) begin
            full_r <= 1'b1;
            if (arr == prev_arr_r) begin
              prev_arr_r <= arr;
              state_r    <= S_DECIDE;
            end else begin
              ptr_r   <= ptr_r + 1'b1;
              sx_r    <= '0;
              sy_r    <= '0;
              pi_r    <= '0;
              state_r <= S_SUMS;
            end
          end else begin
            ptr_r      <= ptr_r + 1'b1;
            prev_arr_r <= arr;
            state_r    <= S_DECIDE;
          end
        end
        S_SUMS: begin
          sx_r <= sx_r + 34'(xi);
          sy_r <= sy_r + 34'(rtt_ring_r[pi_r]);
          if (pi_r == PtrW'(HistDepth - 1)) begin
            pi_r <= '0;
            pj_r <= PtrW'(1);
            den_r <= '0;
            num_r <= '0;
            state_r <= S_PAIR;
          end else begin
            pi_r <= pi_r + 1'b1;
          end
        end
        S_PAIR: begin
          mdx_r   <= dx[33] ? 33'(-dx) : 33'(dx);
          mdy_r   <= dy[32] ? 33'(-dy) : 33'(dy);
          crneg_r <= dx[33] != dy[32];
          state_r <= S_PAIRMUL;
        end
        S_PAIRMUL: begin
          sq_r    <= mul_p;
          state_r <= S_PAIRACC;
        end
        S_PAIRACC: begin
          den_r <= den_r + DivW'(sq_r);
          num_r <= crneg_r ? num_r - DivW'(mul_p) : num_r + DivW'(mul_p);
          if (pj_r == PtrW'(HistDepth - 1)) begin
            if (pi_r == PtrW'(HistDepth - 2)) state_r <= S_SLOPE;
            else begin
              pi_r <= pi_r + 1'b1;
              pj_r <= pi_r + 2'd2;
              state_r <= S_PAIR;
            end
          end else begin
            pj_r <= pj_r + 1'b1;
            state_r <= S_PAIR;
          end
        end
        S_SLOPE: begin
          prev_arr_r <= arr;
          if (den_r == '0) begin
            slope_r <= '0;
            sneg_r  <= 1'b0;
            state_r <= S_LEVER;
          end else begin
            sneg_r <= num_r[DivW-1];
            dreq.dividend <= (num_r[DivW-1] ? -num_r : num_r) << 16;
            dreq.divisor  <= den_r;
            dreq.start    <= 1'b1;
            state_r <= S_SLOPEW;
          end
        end
        S_SLOPEW: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            slope_r <= drsp.quotient[63:0];
            state_r <= S_LEVER;
          end
        end
        S_LEVER: begin
          pacc_r  <= '0;
          state_r <= S_PMUL0;
        end
        S_PMUL0: begin pacc_r <= pacc_r + DivW'(mul_p); state_r <= S_PMUL1; end
        S_PMUL1: begin pacc_r <= pacc_r + (DivW'(mul_p) << 18); state_r <= S_PMUL2; end
        S_PMUL2: begin pacc_r <= pacc_r + (DivW'(mul_p) << 32); state_r <= S_PMUL3; end
        S_PMUL3: begin pacc_r <= pacc_r + (DivW'(mul_p) << 50); state_r <= S_PSUM; end
        S_PSUM: begin
          if (sneg_r != lneg_r) pacc_r <= (DivW'(sy_r) << 16) - ptot;
          else pacc_r <= (DivW'(sy_r) << 16) + ptot;
          state_r <= S_PCLAMP;
        end
        S_PCLAMP: begin
          // A negative line value falls back to the floor; a huge one saturates.
          if (pacc_r[DivW-1]) rtt_r <= floor_r;
          else if (pq[DivW-1:32] != '0) rtt_r <= '1;
          else if (pq[31:0] > floor_r) rtt_r <= pq[31:0];
          else rtt_r <= floor_r;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (rtt_r > {16'd0, tmo}) begin
            if (holdoff_r == '0) begin
              half_r  <= (tmo[15:1] == 15'd0) ? 32'd1 : {17'd0, tmo[15:1]};
              state_r <= S_FACT;
            end else begin
              holdoff_r <= holdoff_r - 1'b1;
              state_r   <= S_OUT;
            end
          end else begin
            dreq.dividend <= DivW'(GrowNum);
            dreq.divisor  <= DivW'(win_r);
            dreq.start    <= 1'b1;
            state_r <= S_GROWW;
          end
        end
        S_FACT: begin
          dreq.dividend <= DivW'(rtt_r - half_r);
          dreq.divisor  <= DivW'(half_r);
          dreq.start    <= 1'b1;
          state_r <= S_FACTW;
        end
        S_FACTW: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            half_r  <= (drsp.quotient[31:0] == '0) ? 32'd1 : drsp.quotient[31:0];
            state_r <= S_WDIV;
          end
        end
        S_WDIV: begin
          dreq.dividend <= DivW'({16'd0, win_r}) + DivW'(half_r) - DivW'(1);
          dreq.divisor  <= DivW'(half_r);
          dreq.start    <= 1'b1;
          state_r <= S_WDIVW;
        end
        S_WDIVW: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            win_r     <= (drsp.quotient[15:0] == 16'd0) ? 16'd1 : drsp.quotient[15:0];
            acc_r     <= {((drsp.quotient[15:0] == 16'd0) ? 16'd1 : drsp.quotient[15:0]),
                          16'd0};
            holdoff_r <= last_seq_r - item_r.seq_number;
            state_r   <= S_OUT;
          end
        end
        S_GROWW: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            if (33'(acc_r) + 33'(drsp.quotient[16:0]) > {1'b0, MaxWindow, 16'd0}) begin
              acc_r <= {MaxWindow, 16'd0};
              win_r <= MaxWindow;
            end else begin
              acc_r <= acc_r + 32'(drsp.quotient[16:0]);
              win_r <= 16'((acc_r + 32'(drsp.quotient[16:0])) >> 16);
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_r.cwnd          <= win_r;
          out_r.timeout_value <= tmo;
          out_r.rtt_used      <= (item_r.opcode == OpAck) ? rtt_r : 32'd0;
          out_r.min_rtt       <= floor_r;
          out_valid_r         <= 1'b1;
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The lever is captured in the slope step, before prev_arr_r moves on.
  always_ff @(posedge clk) begin
    if (state_r == S_SLOPE) begin
      lneg_r  <= lever_s[35];
      lever_r <= lever_s[35] ? 36'(-lever_s) : lever_s;
    end
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("accepting while busy");
  a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    win_r != 16'd0) else $error("window reached zero");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT) else $error("stray result");
  a_acc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> acc_r[31:16] == win_r) else $error("accumulator mismatch");

endmodule
